@@ rtl/bql_pkg.sv @@
// Shared types and constants for the three-channel biquad low-pass core.
package bql_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int CHAN_W     = 2;
    localparam int DATA_W     = 32;
    localparam int COEF_W     = 13;
    localparam int PROD_W     = COEF_W + DATA_W;
    localparam int SUM_W      = SAMPLE_W + 3;
    localparam int FRAC_BITS  = 10;
    localparam int OUT_SHIFT  = 5;
    localparam int CFG_IDX_W  = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_COEF_ONE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_TWO = CFG_IDX_W'(1);

    // -1.375 and 0.53125 in Q10
    localparam logic signed [COEF_W-1:0] COEF_ONE_RESET = -13'sd1408;
    localparam logic signed [COEF_W-1:0] COEF_TWO_RESET = 13'sd544;

    // one history entry per channel
    typedef struct packed {
        logic signed [DATA_W-1:0]   y2;
        logic signed [DATA_W-1:0]   y1;
        logic signed [SAMPLE_W-1:0] x2;
        logic signed [SAMPLE_W-1:0] x1;
    } t_hist;

endpackage

@@ rtl/bql_hist_mem.sv @@
// Per-channel history memory, registered read, entry valid bits for reset.
module bql_hist_mem
    import bql_pkg::*;
#(
    parameter int DEPTH = 3,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_hist         o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_hist         i_wr_data
);

    t_hist              r_mem [DEPTH];
    logic [DEPTH-1:0]   r_ent_vld;
    t_hist              r_rd_data;
    logic               r_rd_ent;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld <= '0;
            r_rd_ent  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_ent_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_ent <= r_ent_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_ent ? r_rd_data : '0;

endmodule

@@ rtl/bql_mac.sv @@
// Biquad arithmetic: feedback products in one stage, final sum in the next.
module bql_mac
    import bql_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic signed [SAMPLE_W-1:0] i_x0,
    input  t_hist                      i_hist,
    input  logic signed [COEF_W-1:0]   i_coef_one,
    input  logic signed [COEF_W-1:0]   i_coef_two,
    output logic signed [DATA_W-1:0]   o_y,
    output t_hist                      o_new_hist
);

    logic signed [SUM_W-1:0]    r_sum;
    logic signed [PROD_W-1:0]   r_p1;
    logic signed [PROD_W-1:0]   r_p2;
    logic signed [SAMPLE_W-1:0] r_x0;
    logic signed [SAMPLE_W-1:0] r_x1;
    logic signed [DATA_W-1:0]   r_y1;

    logic signed [SUM_W-1:0]    n_sum;
    logic signed [PROD_W-1:0]   q1;
    logic signed [PROD_W-1:0]   q2;

    assign n_sum = SUM_W'(i_x0) + (SUM_W'(i_hist.x1) <<< 1) + SUM_W'(i_hist.x2);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= n_sum;
            r_p1  <= PROD_W'(i_coef_one) * PROD_W'(i_hist.y1);
            r_p2  <= PROD_W'(i_coef_two) * PROD_W'(i_hist.y2);
            r_x0  <= i_x0;
            r_x1  <= i_hist.x1;
            r_y1  <= i_hist.y1;
        end
    end

    // floor shifts, then wrap to 32 bits
    assign q1  = r_p1 >>> FRAC_BITS;
    assign q2  = r_p2 >>> FRAC_BITS;
    assign o_y = DATA_W'(r_sum) - DATA_W'(q1) - DATA_W'(q2);

    assign o_new_hist = '{y2: r_y1, y1: o_y, x2: r_x1, x1: r_x0};

endmodule

@@ rtl/three_channel_biquad_lowpass_core.sv @@
// Pipeline: an accepted word passes the history read, the multiply and the sum;
// the sum is registered at the output. Throughput: one word per cycle while the
// output is not stalled and consecutive words name different channels; a word on
// the same channel as its predecessor waits for the history write-back (the
// multiply stage needs the previous y of that channel). Reset: synchronous active
// low; histories read as zero, coefficients return to -1.375 and 0.53125 in Q10.
module three_channel_biquad_lowpass_core
    import bql_pkg::*;
#(
    parameter int NUM_CHANNELS = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [SAMPLE_W-1:0]   i_s_tdata,   // [15:0] sample
    input  logic [CHAN_W-1:0]     i_s_tuser,   // [1:0] channel
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [DATA_W-1:0]     o_m_tdata,   // [31:0] filtered
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [COEF_W-1:0]     i_cfg_data
);

    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int XW = ((AW > CHAN_W) ? AW : CHAN_W) + 1;

    logic signed [COEF_W-1:0]   r_coef_one;
    logic signed [COEF_W-1:0]   r_coef_two;

    logic                       r_s1_vld;
    logic                       r_s1_ok;
    logic [AW-1:0]              r_s1_idx;
    logic signed [SAMPLE_W-1:0] r_s1_x0;

    logic                       r_s2_vld;
    logic                       r_s2_ok;
    logic [AW-1:0]              r_s2_idx;

    logic                       r_out_vld;
    logic [DATA_W-1:0]          r_out_data;

    logic                       r_wb_vld;
    logic [AW-1:0]              r_wb_idx;
    t_hist                      r_wb_data;

    logic [XW-1:0]              in_ch;
    logic                       in_ok;
    logic [AW-1:0]              in_idx;
    logic                       adv;
    logic                       hazard;
    logic                       accept;
    logic                       wr_en;
    t_hist                      rd_data;
    t_hist                      s1_hist;
    t_hist                      new_hist;
    logic signed [DATA_W-1:0]   y;
    logic [DATA_W-1:0]          n_out_data;

    assign in_ch  = XW'(i_s_tuser);
    assign in_ok  = in_ch < XW'(NUM_CHANNELS);
    assign in_idx = in_ch[AW-1:0];

    assign adv    = !r_out_vld || i_m_tready;
    // same channel back to back: wait until the older word reaches write-back
    assign hazard = r_s1_vld && r_s1_ok && in_ok && (in_idx == r_s1_idx);
    assign o_s_tready = adv && !hazard;
    assign accept = i_s_tvalid && o_s_tready;
    assign wr_en  = adv && r_s2_vld && r_s2_ok;

    // configuration
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_one <= COEF_ONE_RESET;
            r_coef_two <= COEF_TWO_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_COEF_ONE: r_coef_one <= i_cfg_data;
                CFG_COEF_TWO: r_coef_two <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bql_hist_mem #(
        .DEPTH (NUM_CHANNELS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept && in_ok),
        .i_rd_addr (in_idx),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s2_idx),
        .i_wr_data (new_hist)
    );

    // the read taken alongside a write to the same entry sees the old data
    assign s1_hist = (r_wb_vld && (r_wb_idx == r_s1_idx)) ? r_wb_data : rd_data;

    bql_mac u_mac (
        .i_clk      (i_clk),
        .i_en       (adv),
        .i_x0       (r_s1_x0),
        .i_hist     (s1_hist),
        .i_coef_one (r_coef_one),
        .i_coef_two (r_coef_two),
        .o_y        (y),
        .o_new_hist (new_hist)
    );

    assign n_out_data = r_s2_ok ? DATA_W'(y <<< OUT_SHIFT) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_wb_vld  <= 1'b0;
        end else begin
            if (adv) begin
                r_s1_vld  <= accept;
                r_s2_vld  <= r_s1_vld;
                r_out_vld <= r_s2_vld;
            end
            if (wr_en) begin
                r_wb_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ok  <= in_ok;
            r_s1_idx <= in_idx;
            r_s1_x0  <= signed'(i_s_tdata);
        end
        if (adv) begin
            r_s2_ok    <= r_s1_ok;
            r_s2_idx   <= r_s1_idx;
            r_out_data <= n_out_data;
        end
        if (wr_en) begin
            r_wb_idx  <= r_s2_idx;
            r_wb_data <= new_hist;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;

    // two words of one channel never sit in adjacent stages
    a_no_same_chan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_s2_vld && r_s1_ok && r_s2_ok) |-> (r_s1_idx != r_s2_idx))
        else $error("same channel in multiply and sum stages");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_vld)
        else $error("accepted word lost before multiply stage");

    a_hazard_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hazard |-> !o_s_tready)
        else $error("input ready during channel hazard");

    a_write_enters_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> (r_wb_vld && r_wb_idx == $past(r_s2_idx)))
        else $error("write-back forward register not updated");

endmodule

@@ test/tb_three_channel_biquad_lowpass_core.sv @@
// Testbench for the three-channel biquad low-pass core: stream driver, monitor, filter predictor.
module tb_three_channel_biquad_lowpass_core;
    import bql_pkg::*;

    localparam int NUM_CH = 3;
    localparam int LIMIT_TIME = 400000;
    localparam int TAIL_CYCLES = 16;

    localparam logic [CHAN_W-1:0] CH_ROLL    = CHAN_W'(0);
    localparam logic [CHAN_W-1:0] CH_PITCH   = CHAN_W'(1);
    localparam logic [CHAN_W-1:0] CH_YAW     = CHAN_W'(2);
    localparam logic [CHAN_W-1:0] CH_INVALID = CHAN_W'(3);

    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = '1;

    localparam logic signed [COEF_W-1:0] COEF_MIN = -13'sd4096;
    localparam logic signed [COEF_W-1:0] COEF_MAX = 13'sd4095;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'h7fff;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 16'h8000;

    // channel patterns for random runs
    localparam int RUN_SAME   = 0;
    localparam int RUN_ROTATE = 1;
    localparam int RUN_MIXED  = 2;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [CHAN_W-1:0]   channel;
    } t_sensor_word;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [SAMPLE_W-1:0]   i_s_tdata = '0;    // [15:0] sample
    logic [CHAN_W-1:0]     i_s_tuser = '0;    // [1:0] channel
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b1;
    logic [DATA_W-1:0]     o_m_tdata;         // [31:0] filtered
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [COEF_W-1:0]     i_cfg_data = '0;

    three_channel_biquad_lowpass_core #(
        .NUM_CHANNELS (NUM_CH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // filter state mirrored from the core
    logic signed [COEF_W-1:0]   coef_one = COEF_ONE_RESET;
    logic signed [COEF_W-1:0]   coef_two = COEF_TWO_RESET;
    logic signed [SAMPLE_W-1:0] x_prev1 [NUM_CH] = '{default: '0};
    logic signed [SAMPLE_W-1:0] x_prev2 [NUM_CH] = '{default: '0};
    logic signed [DATA_W-1:0]   y_prev1 [NUM_CH] = '{default: '0};
    logic signed [DATA_W-1:0]   y_prev2 [NUM_CH] = '{default: '0};

    t_sensor_word       sensor_q [$];
    logic [DATA_W-1:0]  filtered_q [$];

    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;

    function automatic logic [DATA_W-1:0] filter_step(logic signed [SAMPLE_W-1:0] x0,
                                                      logic [CHAN_W-1:0] ch);
        longint                   sum;
        longint                   fb_one;
        longint                   fb_two;
        longint                   y_full;
        logic signed [DATA_W-1:0] sum32;
        logic signed [DATA_W-1:0] y32;
        if (ch >= NUM_CH)
            return '0;
        sum = longint'(x0) + 2 * longint'(x_prev1[ch]) + longint'(x_prev2[ch]);
        sum32 = sum[DATA_W-1:0];
        // signed longint shift floors, as the core does
        fb_one = (longint'(coef_one) * longint'(y_prev1[ch])) >>> FRAC_BITS;
        fb_two = (longint'(coef_two) * longint'(y_prev2[ch])) >>> FRAC_BITS;
        y_full = longint'(sum32) - fb_one - fb_two;
        y32 = y_full[DATA_W-1:0];
        x_prev2[ch] = x_prev1[ch];
        x_prev1[ch] = x0;
        y_prev2[ch] = y_prev1[ch];
        y_prev1[ch] = y32;
        return y32 << OUT_SHIFT;
    endfunction

    // driver
    always @(posedge i_clk) begin
        t_sensor_word w;
        if (i_rst_n && i_s_tvalid && o_s_tready)
            filtered_q.push_back(filter_step(i_s_tdata, i_s_tuser));
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (sensor_q.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
                w = sensor_q.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata <= w.sample;
                i_s_tuser <= w.channel;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        logic [DATA_W-1:0] want;
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (filtered_q.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected output word, expected none, actual %h",
                         $time, o_m_tdata);
            end else begin
                want = filtered_q.pop_front();
                if (o_m_tdata !== want) begin
                    mismatch_count++;
                    $display("%0t: filtered mismatch, expected %h, actual %h",
                             $time, want, o_m_tdata);
                end
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_COEF_ONE)
            coef_one = value;
        else if (idx == CFG_COEF_TWO)
            coef_two = value;
    endtask

    task automatic queue_word(logic [SAMPLE_W-1:0] sample, logic [CHAN_W-1:0] ch);
        t_sensor_word w;
        w.sample = sample;
        w.channel = ch;
        sensor_q.push_back(w);
    endtask

    task automatic queue_random_words(int count);
        int           left;
        int           pattern;
        int           run_len;
        logic [CHAN_W-1:0] ch;
        logic [SAMPLE_W-1:0] s;
        left = count;
        ch = CH_ROLL;
        while (left > 0) begin
            pattern = $urandom_range(RUN_MIXED);
            run_len = $urandom_range(1, 8);
            for (int k = 0; k < run_len && left > 0; k++) begin
                // same-channel runs exercise the write-back stall
                case (pattern)
                    RUN_SAME: begin
                    end
                    RUN_ROTATE: begin
                        ch = (ch >= CH_YAW) ? CH_ROLL : ch + 1'b1;
                    end
                    default: begin
                        ch = ($urandom_range(9) == 0) ? CH_INVALID
                                                      : CHAN_W'($urandom_range(CH_YAW));
                    end
                endcase
                if ($urandom_range(7) == 0)
                    s = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
                else
                    s = SAMPLE_W'($urandom);
                queue_word(s, ch);
                left--;
            end
        end
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (sensor_q.size() != 0 || i_s_tvalid || filtered_q.size() != 0);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // phase 1: reset coefficients, sender idles lightly, receiver often
        send_gap_pct = 19;
        recv_stall_pct = 45;
        queue_word(SAMPLE_MAX, CH_ROLL);
        queue_word(SAMPLE_MIN, CH_PITCH);
        queue_word(SAMPLE_MAX, CH_YAW);
        queue_word(SAMPLE_MIN, CH_INVALID);
        queue_word(SAMPLE_MAX, CH_INVALID);
        queue_word(SAMPLE_MAX, CH_ROLL);
        queue_word(SAMPLE_MAX, CH_ROLL);
        queue_word(SAMPLE_MAX, CH_ROLL);
        queue_word(SAMPLE_MIN, CH_PITCH);
        queue_word(SAMPLE_MIN, CH_PITCH);
        queue_word(SAMPLE_MIN, CH_PITCH);
        queue_word(16'hffff, CH_YAW);
        queue_word(16'h0001, CH_YAW);
        queue_word(16'h0000, CH_YAW);
        queue_word(16'h0000, CH_ROLL);
        queue_word(16'hffff, CH_INVALID);
        queue_word(SAMPLE_MIN, CH_ROLL);
        queue_word(SAMPLE_MAX, CH_PITCH);
        queue_word(SAMPLE_MIN, CH_YAW);
        queue_word(16'h5555, CH_ROLL);
        queue_word(16'haaaa, CH_ROLL);
        queue_word(16'h0000, CH_PITCH);
        queue_word(16'h0000, CH_YAW);
        queue_random_words(327);
        wait_drained();

        // extremes of both coefficients, plus a write to a missing register
        write_reg(CFG_COEF_ONE, COEF_MIN);
        write_reg(CFG_COEF_TWO, COEF_MAX);
        write_reg(CFG_NO_REG, 13'h0aaa);
        queue_random_words(350);
        wait_drained();

        // phase 2: roles swapped
        send_gap_pct = 45;
        recv_stall_pct = 19;
        write_reg(CFG_COEF_ONE, COEF_MAX);
        write_reg(CFG_COEF_TWO, COEF_MIN);
        queue_random_words(350);
        wait_drained();

        // phase 3: no idling on either side
        send_gap_pct = 0;
        recv_stall_pct = 0;
        write_reg(CFG_IDX_W'($urandom_range(2, 254)), COEF_W'($urandom));
        write_reg(CFG_COEF_ONE, COEF_W'($urandom));
        write_reg(CFG_COEF_TWO, COEF_W'($urandom));
        queue_random_words(200);
        wait_drained();

        write_reg(CFG_COEF_ONE, COEF_ONE_RESET);
        write_reg(CFG_COEF_TWO, COEF_TWO_RESET);
        queue_random_words(200);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (filtered_q.size() != 0) begin
            mismatch_count++;
            $display("%0t: %0d expected words never arrived", $time, filtered_q.size());
        end
        if (mismatch_count == 0) begin
            $display("tb_three_channel_biquad_lowpass_core: done, clean");
        end else begin
            $display("tb_three_channel_biquad_lowpass_core: done, errors");
        end
        $finish;
    end

    initial begin
        #LIMIT_TIME;
        $display("%0t: timeout", $time);
        $display("tb_three_channel_biquad_lowpass_core: done, errors");
        $finish;
    end

endmodule

@@ three_channel_biquad_lowpass_core.f @@
rtl/bql_pkg.sv
rtl/bql_hist_mem.sv
rtl/bql_mac.sv
rtl/three_channel_biquad_lowpass_core.sv
test/tb_three_channel_biquad_lowpass_core.sv
